@@ design/first_fit_range_allocator_assert.svh @@
// Assertion macros shared by the checkers of the range allocator.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFRA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("range allocator check failed");

// Next-cycle implication.
`define FFRA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("range allocator check failed");

`endif

@@ design/ffra_pkg.sv @@
`default_nettype none

package ffra_pkg;

    localparam int unsigned START_W = 24;
    localparam int unsigned SIZE_W  = 25;
    localparam int unsigned ENTRY_W = START_W + SIZE_W;

    // Largest usable capacity: a start has 24 bits.
    localparam logic [SIZE_W-1:0] LOC_LIMIT = 25'h100_0000;
    localparam logic [SIZE_W-1:0] CAP_RESET = 25'd131072;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESIZE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Request handed from the channel side to the engine.
    typedef struct packed {
        logic [1:0]         op;
        logic [SIZE_W-1:0]  request_size;
        logic [1:0]         pool_id;
        logic [START_W-1:0] location;
        logic [SIZE_W-1:0]  old_size;
    } ffra_req_t;

    // Result handed back from the engine.
    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         pool;
        logic [START_W-1:0] location;
    } ffra_result_t;

endpackage

`default_nettype wire

@@ design/first_fit_range_allocator.sv @@
// First-fit range allocator over a fixed set of pools.
// Input channel s_*: one request per transfer (reserve, free or resize).
// Result channel m_*: exactly one result per request, in request order.
// Config channel cfg_*: writes pool_capacity; ready whenever out of reset,
// write it only while no request is in flight.
// Each pool keeps its used ranges sorted by start in one shared table RAM;
// a single sequencer and one add/compare unit walk it an entry at a time.
// The scan walks the stored entries of each pool it visits in turn, and
// inserting or removing a range moves every later entry by one slot.
// One request is handled at a time: s_ready stays low from acceptance until
// its result has been taken on m_*.
// If the receiver stalls, the result holds on m_* and no new request is
// taken. Reset empties every pool and loads the default capacity 131072;
// table contents need no clearing since only counted entries are read.
`default_nettype none

module first_fit_range_allocator #(
    parameter int unsigned POOLS      = 4,
    parameter int unsigned MAX_RANGES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [24:0] s_request_size,
    input  wire logic [1:0]  s_pool_id,
    input  wire logic [23:0] s_location,
    input  wire logic [24:0] s_old_size,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_result_pool,
    output logic [23:0]      m_result_location,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [24:0] cfg_data
);

    logic [ffra_pkg::SIZE_W-1:0] cap_reg;
    logic [ffra_pkg::SIZE_W-1:0] cap_eff;
    logic                        m_valid_reg;
    ffra_pkg::ffra_result_t      out_reg;
    ffra_pkg::ffra_req_t         req;
    ffra_pkg::ffra_result_t      eng_result;
    logic                        eng_idle;
    logic                        eng_done;
    logic                        start;

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && eng_idle && !m_valid_reg;
    assign start     = s_valid && s_ready;
    assign req       = '{s_op, s_request_size, s_pool_id, s_location, s_old_size};

    // Clamp capacity to the start range
    assign cap_eff = (cap_reg > ffra_pkg::LOC_LIMIT) ? ffra_pkg::LOC_LIMIT : cap_reg;

    ffra_engine #(
        .POOLS     (POOLS),
        .MAX_RANGES(MAX_RANGES)
    ) u_engine (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start),
        .req    (req),
        .cap    (cap_eff),
        .idle   (eng_idle),
        .done   (eng_done),
        .result (eng_result)
    );

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= ffra_pkg::CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // Hold result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_done) begin
            out_reg <= eng_result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_result_pool     = out_reg.pool;
    assign m_result_location = out_reg.location;

endmodule

`default_nettype wire

@@ design/ffra_ram.sv @@
`default_nettype none

module ffra_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/ffra_engine.sv @@
`default_nettype none

module ffra_engine #(
    parameter int unsigned POOLS      = 4,
    parameter int unsigned MAX_RANGES = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire ffra_pkg::ffra_req_t         req,
    input  wire logic [ffra_pkg::SIZE_W-1:0] cap,
    output logic                             idle,
    output logic                             done,
    output ffra_pkg::ffra_result_t           result
);

    localparam int unsigned DEPTH = POOLS * MAX_RANGES;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned IW    = $clog2(MAX_RANGES);
    localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
    localparam int unsigned PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int unsigned PCW   = $clog2(POOLS + 1);
    localparam int unsigned EW    = ffra_pkg::ENTRY_W;
    localparam int unsigned SW    = ffra_pkg::START_W;
    localparam int unsigned NW    = ffra_pkg::SIZE_W;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0_0000_0000_0001,
        S_DISP    = 13'b0_0000_0000_0010,
        S_LOOK_RD = 13'b0_0000_0000_0100,
        S_LOOK_CK = 13'b0_0000_0000_1000,
        S_REM_RD  = 13'b0_0000_0001_0000,
        S_REM_WR  = 13'b0_0000_0010_0000,
        S_POOL    = 13'b0_0000_0100_0000,
        S_SCAN_RD = 13'b0_0000_1000_0000,
        S_SCAN_CK = 13'b0_0001_0000_0000,
        S_END_CK  = 13'b0_0010_0000_0000,
        S_INS_RD  = 13'b0_0100_0000_0000,
        S_INS_WR  = 13'b0_1000_0000_0000,
        S_PUT     = 13'b1_0000_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    ffra_pkg::ffra_req_t    rq_reg, rq_next;
    logic [PCW-1:0]         p_reg, p_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [SW-1:0]          at_reg, at_next;
    logic [NW:0]            b_reg, b_next;
    logic [CW-1:0]          cnt_reg [POOLS];
    logic [CW-1:0]          cnt_next [POOLS];
    logic                   done_reg, done_next;
    ffra_pkg::ffra_result_t res_reg, res_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic [PW-1:0] pidx;
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] i_m1;
    logic [SW-1:0] rd_start;
    logic [NW-1:0] rd_len;
    logic [NW:0]   rd_end;
    logic          gap_fit;
    logic          end_fit;
    logic          grow;

    function automatic logic [AW-1:0] ent_addr(input logic [PW-1:0] p,
                                               input logic [CW-1:0] i);
        logic [AW-1:0] base;
        base = AW'(p) * AW'(MAX_RANGES);
        return base + AW'(i[IW-1:0]);
    endfunction

    ffra_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Shared compare unit: entry end, gap test and end-of-pool test.
    assign pidx     = p_reg[PW-1:0];
    assign cnt_cur  = (p_reg < PCW'(POOLS)) ? cnt_reg[pidx] : '0;
    assign i_m1     = i_reg - CW'(1);
    assign rd_start = ram_rdata[EW-1:NW];
    assign rd_len   = ram_rdata[NW-1:0];
    assign rd_end   = (NW+1)'(rd_start) + (NW+1)'(rd_len);
    assign gap_fit  = ((NW+2)'(rd_start) >= (NW+2)'(b_reg)) &&
                      (((NW+2)'(rd_start) - (NW+2)'(b_reg)) >= (NW+2)'(rq_reg.request_size));
    assign end_fit  = (((NW+2)'(b_reg) + (NW+2)'(rq_reg.request_size)) <= (NW+2)'(cap)) &&
                      (b_reg[NW:SW] == '0);
    assign grow     = (rq_reg.op == ffra_pkg::OP_RESIZE) &&
                      (rq_reg.request_size > rq_reg.old_size);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        rq_next    = rq_reg;
        p_next     = p_reg;
        i_next     = i_reg;
        pos_next   = pos_reg;
        at_next    = at_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = ent_addr(pidx, i_reg);
        ram_wdata  = ram_rdata;
        ram_raddr  = ent_addr(pidx, i_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    rq_next    = req;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                priority if (rq_reg.op == ffra_pkg::OP_RESERVE) begin
                    p_next     = '0;
                    state_next = S_POOL;
                end else if ((rq_reg.op == ffra_pkg::OP_FREE ||
                              rq_reg.op == ffra_pkg::OP_RESIZE) &&
                             (32'(rq_reg.pool_id) < POOLS)) begin
                    p_next     = PCW'(rq_reg.pool_id);
                    i_next     = '0;
                    state_next = S_LOOK_RD;
                end else if (grow) begin
                    p_next     = '0;
                    state_next = S_POOL;
                end else begin
                    done_next  = 1'b1;
                    res_next   = '{ffra_pkg::ST_NOT_FOUND, 2'd0, '0};
                    state_next = S_IDLE;
                end
            end
            S_LOOK_RD: begin
                priority if (i_reg < cnt_cur) begin
                    state_next = S_LOOK_CK;
                end else if (grow) begin
                    p_next     = '0;
                    state_next = S_POOL;
                end else begin
                    done_next  = 1'b1;
                    res_next   = '{ffra_pkg::ST_NOT_FOUND, 2'd0, '0};
                    state_next = S_IDLE;
                end
            end
            S_LOOK_CK: begin
                priority if (rd_start != rq_reg.location) begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_LOOK_RD;
                end else if (rq_reg.op == ffra_pkg::OP_RESIZE && !grow) begin
                    // Shrink in place
                    ram_we     = 1'b1;
                    ram_wdata  = {rq_reg.location, rq_reg.request_size};
                    done_next  = 1'b1;
                    res_next   = '{ffra_pkg::ST_DONE, rq_reg.pool_id, rq_reg.location};
                    state_next = S_IDLE;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_REM_RD;
                end
            end
            S_REM_RD: begin
                if (i_reg < cnt_cur) begin
                    state_next = S_REM_WR;
                end else begin
                    cnt_next[pidx] = cnt_cur - CW'(1);
                    if (grow) begin
                        p_next     = '0;
                        state_next = S_POOL;
                    end else begin
                        done_next  = 1'b1;
                        res_next   = '{ffra_pkg::ST_DONE, rq_reg.pool_id, rq_reg.location};
                        state_next = S_IDLE;
                    end
                end
            end
            S_REM_WR: begin
                // Move entry down one slot
                ram_we     = 1'b1;
                ram_waddr  = ent_addr(pidx, i_m1);
                i_next     = i_reg + CW'(1);
                state_next = S_REM_RD;
            end
            S_POOL: begin
                priority if (p_reg == PCW'(POOLS)) begin
                    done_next  = 1'b1;
                    res_next   = '{ffra_pkg::ST_NO_ROOM, 2'd0, '0};
                    state_next = S_IDLE;
                end else if (rq_reg.request_size > cap ||
                             cnt_cur >= CW'(MAX_RANGES)) begin
                    p_next = p_reg + PCW'(1);
                end else if (cnt_cur == '0) begin
                    pos_next   = '0;
                    at_next    = '0;
                    i_next     = '0;
                    state_next = S_INS_RD;
                end else begin
                    i_next     = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                priority if (i_reg == '0 && NW'(rd_start) >= rq_reg.request_size) begin
                    pos_next   = '0;
                    at_next    = '0;
                    i_next     = cnt_cur;
                    state_next = S_INS_RD;
                end else if (i_reg != '0 && gap_fit) begin
                    pos_next   = i_reg;
                    at_next    = b_reg[SW-1:0];
                    i_next     = cnt_cur;
                    state_next = S_INS_RD;
                end else begin
                    b_next = rd_end;
                    i_next = i_reg + CW'(1);
                    if (i_reg + CW'(1) >= cnt_cur) begin
                        state_next = S_END_CK;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_END_CK: begin
                if (end_fit) begin
                    pos_next   = cnt_cur;
                    at_next    = b_reg[SW-1:0];
                    i_next     = cnt_cur;
                    state_next = S_INS_RD;
                end else begin
                    p_next     = p_reg + PCW'(1);
                    state_next = S_POOL;
                end
            end
            S_INS_RD: begin
                ram_raddr = ent_addr(pidx, i_m1);
                if (i_reg <= pos_reg) begin
                    state_next = S_PUT;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                // Move entry up one slot
                ram_we     = 1'b1;
                i_next     = i_m1;
                state_next = S_INS_RD;
            end
            S_PUT: begin
                ram_we         = 1'b1;
                ram_waddr      = ent_addr(pidx, pos_reg);
                ram_wdata      = {at_reg, rq_reg.request_size};
                cnt_next[pidx] = cnt_cur + CW'(1);
                done_next      = 1'b1;
                res_next       = '{ffra_pkg::ST_DONE, 2'(p_reg), at_reg};
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int k = 0; k < POOLS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        rq_reg  <= rq_next;
        p_reg   <= p_next;
        i_reg   <= i_next;
        pos_reg <= pos_next;
        at_reg  <= at_next;
        b_reg   <= b_next;
        res_reg <= res_next;
    end

    assign idle   = (state_reg == S_IDLE) && !done_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ design/ffra_checker.sv @@
`default_nettype none

`include "first_fit_range_allocator_assert.svh"

module ffra_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [1:0]  m_result_pool,
    input wire logic [23:0] m_result_location
);

    // Stalled result holds
    `FFRA_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_result_pool) && $stable(m_result_location))

    // Busy right after a request is taken
    `FFRA_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // No request is taken while a result waits
    `FFRA_ASSERT_IMP(a_one_in_flight, m_valid, !s_ready)

    // A failed reserve reports pool and location zero
    `FFRA_ASSERT_IMP(a_no_room_zero, m_valid && m_status == ffra_pkg::ST_NO_ROOM, m_result_pool == 2'd0 && m_result_location == 24'd0)

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (.*);

`default_nettype wire

@@ tb/first_fit_range_allocator_tb.sv @@
`default_nettype none

module first_fit_range_allocator_tb;

    localparam int NPOOL      = 4;
    localparam int NRANGE     = 64;
    localparam int START_W    = ffra_pkg::START_W;
    localparam int SIZE_W     = ffra_pkg::SIZE_W;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        ffra_pkg::status_t  status;
        logic [1:0]         pool;
        logic [START_W-1:0] location;
    } alloc_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic [1:0]         s_op = ffra_pkg::OP_RESERVE;
    logic [SIZE_W-1:0]  s_request_size = '0;
    logic [1:0]         s_pool_id = '0;
    logic [START_W-1:0] s_location = '0;
    logic [SIZE_W-1:0]  s_old_size = '0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire  [1:0]         m_status;
    wire  [1:0]         m_result_pool;
    wire  [START_W-1:0] m_result_location;
    logic               cfg_valid = 1'b0;
    wire                cfg_ready;
    logic [SIZE_W-1:0]  cfg_data = '0;

    first_fit_range_allocator #(.POOLS(NPOOL), .MAX_RANGES(NRANGE)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_request_size(s_request_size), .s_pool_id(s_pool_id),
        .s_location(s_location), .s_old_size(s_old_size),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_result_pool(m_result_pool), .m_result_location(m_result_location),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Shadow copy of the pool tables
    logic [SIZE_W-1:0]  shadow_cap;
    logic [START_W-1:0] shadow_start [NPOOL][NRANGE];
    logic [SIZE_W-1:0]  shadow_len   [NPOOL][NRANGE];
    int                 shadow_count [NPOOL];

    alloc_result_t pending_results[$];
    int     mismatches = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     hold_left = 0;
    longint cycles = 0;

    always #2 aclk = ~aclk;

    // Abort on a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint eff_cap();
        return (shadow_cap > ffra_pkg::LOC_LIMIT) ? longint'(ffra_pkg::LOC_LIMIT)
                                                  : longint'(shadow_cap);
    endfunction

    // Try to place n slots in pool p; insert on success
    function automatic bit place_in_pool(int p, longint n, output logic [START_W-1:0] at);
        int     cnt;
        int     pos;
        longint b;
        longint e;
        longint cap;
        bit     ok;
        cnt = shadow_count[p];
        cap = eff_cap();
        ok = 0;
        pos = 0;
        at = '0;
        if (n > cap || cnt >= NRANGE) return 0;
        if (cnt == 0 || longint'(shadow_start[p][0]) >= n) begin
            ok = 1;
        end else begin
            for (int i = 0; i + 1 < cnt && !ok; i++) begin
                b = longint'(shadow_start[p][i]) + longint'(shadow_len[p][i]);
                e = longint'(shadow_start[p][i+1]);
                if (e >= b && e - b >= n) begin
                    ok = 1;
                    pos = i + 1;
                    at = b[START_W-1:0];
                end
            end
            if (!ok) begin
                b = longint'(shadow_start[p][cnt-1]) + longint'(shadow_len[p][cnt-1]);
                if (b + n <= cap && b < longint'(ffra_pkg::LOC_LIMIT)) begin
                    ok = 1;
                    pos = cnt;
                    at = b[START_W-1:0];
                end
            end
        end
        if (!ok) return 0;
        for (int i = cnt; i > pos; i--) begin
            shadow_start[p][i] = shadow_start[p][i-1];
            shadow_len[p][i]   = shadow_len[p][i-1];
        end
        shadow_start[p][pos] = at;
        shadow_len[p][pos]   = n[SIZE_W-1:0];
        shadow_count[p]      = cnt + 1;
        return 1;
    endfunction

    function automatic alloc_result_t reserve_slots(logic [SIZE_W-1:0] n);
        alloc_result_t r;
        logic [START_W-1:0] at;
        r.status = ffra_pkg::ST_NO_ROOM;
        r.pool = '0;
        r.location = '0;
        for (int p = 0; p < NPOOL; p++) begin
            if (place_in_pool(p, longint'(n), at)) begin
                r.status = ffra_pkg::ST_DONE;
                r.pool = p[1:0];
                r.location = at;
                return r;
            end
        end
        return r;
    endfunction

    function automatic void drop_range(int p, int idx);
        for (int i = idx; i + 1 < shadow_count[p]; i++) begin
            shadow_start[p][i] = shadow_start[p][i+1];
            shadow_len[p][i]   = shadow_len[p][i+1];
        end
        shadow_count[p]--;
    endfunction

    // Expected outcome of one request, updating the shadow tables
    function automatic alloc_result_t predict_alloc(logic [1:0] op, logic [SIZE_W-1:0] req,
            logic [1:0] pid, logic [START_W-1:0] loc, logic [SIZE_W-1:0] old);
        alloc_result_t r;
        int idx;
        r.status = ffra_pkg::ST_NOT_FOUND;
        r.pool = '0;
        r.location = '0;
        idx = -1;
        if (op == ffra_pkg::OP_RESERVE) return reserve_slots(req);
        if (op != ffra_pkg::OP_FREE && op != ffra_pkg::OP_RESIZE) return r;
        if (pid < NPOOL) begin
            for (int i = 0; i < shadow_count[pid] && idx < 0; i++)
                if (shadow_start[pid][i] == loc) idx = i;
        end
        if (op == ffra_pkg::OP_FREE) begin
            if (idx >= 0) begin
                drop_range(pid, idx);
                r.status = ffra_pkg::ST_DONE;
                r.pool = pid;
                r.location = loc;
            end
        end else if (req > old) begin
            if (idx >= 0) drop_range(pid, idx);
            r = reserve_slots(req);
        end else if (idx >= 0) begin
            shadow_len[pid][idx] = req;
            r.status = ffra_pkg::ST_DONE;
            r.pool = pid;
            r.location = loc;
        end
        return r;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_request(logic [1:0] op, logic [SIZE_W-1:0] req, logic [1:0] pid,
            logic [START_W-1:0] loc, logic [SIZE_W-1:0] old);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_request_size <= req;
        s_pool_id      <= pid;
        s_location     <= loc;
        s_old_size     <= old;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_alloc(op, req, pid, loc, old));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        shadow_cap = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Pick a live range; falls back to a random address when all pools are empty
    task automatic pick_live(output logic [1:0] pid, output logic [START_W-1:0] loc,
            output logic [SIZE_W-1:0] len);
        int p;
        int i;
        p = $urandom_range(0, NPOOL - 1);
        for (int k = 0; k < NPOOL && shadow_count[p] == 0; k++) p = (p + 1) % NPOOL;
        pid = p[1:0];
        if (shadow_count[p] == 0) begin
            loc = START_W'($urandom);
            len = SIZE_W'($urandom);
        end else begin
            i = $urandom_range(0, shadow_count[p] - 1);
            loc = shadow_start[p][i];
            len = shadow_len[p][i];
        end
    endtask

    // Check every result transfer; drive the receiver's ready
    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d pool %0d loc %h",
                                 m_status, m_result_pool, m_result_location);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status || m_result_pool !== want.pool ||
                            m_result_location !== want.location) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%h got %0d/%0d/%h",
                                     want.status, want.pool, want.location,
                                     m_status, m_result_pool, m_result_location);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic test_directed_edges();
        logic [1:0] p;
        logic [START_W-1:0] l;
        logic [SIZE_W-1:0] n;
        send_request(ffra_pkg::OP_RESERVE, 25'd0, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_RESERVE, 25'd0, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_RESERVE, 25'd100, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_RESERVE, ffra_pkg::LOC_LIMIT, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_RESERVE, 25'h1FF_FFFF, 2'd3, 24'hFF_FFFF, 25'h1FF_FFFF);
        send_request(ffra_pkg::OP_RESERVE, 25'd131072 - 25'd100, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_RESERVE, 25'd50, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_FREE, 25'd0, 2'd0, 24'd77, 25'd0);
        send_request(ffra_pkg::OP_FREE, 25'd0, 2'd3, 24'hFF_FFFF, 25'd0);
        send_request(ffra_pkg::OP_FREE, 25'd0, 2'd0, 24'd0, 25'd0);
        // shrink, shrink above stored length, grow, grow on a missing range, shrink on a missing range
        send_request(ffra_pkg::OP_RESIZE, 25'd40, 2'd0, 24'd0, 25'd100);
        send_request(ffra_pkg::OP_RESIZE, 25'd90, 2'd0, 24'd0, 25'd100);
        send_request(ffra_pkg::OP_RESIZE, 25'd500, 2'd0, 24'd0, 25'd100);
        send_request(ffra_pkg::OP_RESIZE, 25'd10, 2'd1, 24'd1234, 25'd5);
        send_request(ffra_pkg::OP_RESIZE, 25'd3, 2'd2, 24'd9, 25'd7);
        send_request(2'd3, 25'h1FF_FFFF, 2'd3, 24'hFF_FFFF, 25'h1FF_FFFF);
        pick_live(p, l, n);
        send_request(ffra_pkg::OP_FREE, 25'd0, p, l, n);
        wait_drained();
    endtask

    task automatic test_full_tables();
        write_capacity(25'd256);
        for (int i = 0; i < 4 * NRANGE + 4; i++)
            send_request(ffra_pkg::OP_RESERVE, 25'd1, 2'd0, 24'd0, 25'd0);
        // lowered capacity leaves ranges beyond the end
        write_capacity(25'd1);
        for (int i = 0; i < 6; i++) begin
            send_request(ffra_pkg::OP_FREE, 25'd0, 2'd0, 24'(2 * i), 25'd1);
            send_request(ffra_pkg::OP_RESERVE, 25'(i % 2), 2'd0, 24'd0, 25'd0);
        end
        write_capacity(ffra_pkg::LOC_LIMIT);
        for (int p = 0; p < NPOOL; p++)
            while (shadow_count[p] > 0)
                send_request(ffra_pkg::OP_FREE, 25'd0, p[1:0], shadow_start[p][0], 25'd1);
        send_request(ffra_pkg::OP_RESERVE, ffra_pkg::LOC_LIMIT, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_RESERVE, 25'd0, 2'd0, 24'd0, 25'd0);
        send_request(ffra_pkg::OP_RESERVE, 25'd1, 2'd0, 24'd0, 25'd0);
        wait_drained();
    endtask

    task automatic run_random(int count, logic [SIZE_W-1:0] cap);
        logic [1:0] p;
        logic [START_W-1:0] l;
        logic [SIZE_W-1:0] n;
        logic [SIZE_W-1:0] sz;
        longint lim;
        int sel;
        write_capacity(cap);
        lim = eff_cap() / 12 + 1;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            sz = 25'($urandom_range(0, int'(lim)));
            if (sel < 42) begin
                send_request(ffra_pkg::OP_RESERVE, sz, 2'($urandom), START_W'($urandom),
                             SIZE_W'($urandom));
            end else if (sel < 65) begin
                pick_live(p, l, n);
                send_request(ffra_pkg::OP_FREE, SIZE_W'($urandom), p, l, n);
            end else if (sel < 88) begin
                pick_live(p, l, n);
                if ($urandom_range(0, 1)) n = n + sz;
                send_request(ffra_pkg::OP_RESIZE, sz, p, l, n);
            end else begin
                send_request(2'($urandom), SIZE_W'($urandom), 2'($urandom),
                             START_W'($urandom), SIZE_W'($urandom));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        // long receiver stall while requests keep coming
        hold_left = 600;
        for (int i = 0; i < 6; i++)
            send_request(ffra_pkg::OP_RESERVE, 25'd3, 2'd0, 24'd0, 25'd0);
        wait_drained();
    endtask

    initial begin
        shadow_cap = ffra_pkg::CAP_RESET;
        for (int p = 0; p < NPOOL; p++) shadow_count[p] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 38;
        recv_idle = 70;
        test_directed_edges();
        test_full_tables();
        run_random(330, 25'd4096);
        test_backpressure();

        send_idle = 70;
        recv_idle = 38;
        run_random(300, 25'd131072);
        run_random(60, 25'd1);

        send_idle = 0;
        recv_idle = 0;
        run_random(200, 25'h1FF_FFFF);
        run_random(200, 25'd64);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
